// ----- rtl/core/sgra_pkg.sv -----
// Shared types and codes for the sync group ready aggregator.
package sgra_pkg;

  // command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_DUP    = 2'd1;
  localparam logic [1:0] STAT_ABSENT = 2'd2;

  // word field widths
  localparam int CMD_W    = 2;
  localparam int CLIENT_W = 4;
  localparam int EV_W     = 8;
  localparam int CNT_O_W  = 5;
  localparam int STAT_W   = 2;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch the input word
    logic apply;     // check the command, apply add/remove, read slot mask
    logic upd_wr;    // write back the updated mask
    logic sweep_rd;  // read the next slot of the sweep
    logic finish;    // load the result register, commit the group masks
  } dp_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;        // nothing to rebuild (error or unused command)
    logic is_update;
    logic sweep_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- rtl/core/sync_group_ready_aggregator_core.sv -----
// Top level of the sync group ready aggregator.
// Keeps one synchronization group of CLIENTS member slots, each with an
// EVENT_BITS ready mask, and answers every command word with one result word.
// Input channel in_*: one command word per handshake (add, remove, update).
// Output channel out_*: one result word per command, in command order.
// A command is taken only while the sequencer is idle. After acceptance the
// slot is checked and changed, then one memory read per cycle sweeps all
// CLIENTS slots to rebuild the group AND/OR; that sweep sets the rate.
// From acceptance to out_tvalid, add/remove pass check, sweep, tail and
// result load; update adds a mask read-modify-write before the sweep; a
// rejected or unused command goes from check straight to the result load.
// The next command is taken in the cycle after the result is loaded.
// A result waits in the output register while out_tready is low; the next
// command may be accepted and worked on meanwhile, and it stalls only at its
// own result load until the register frees up.
// Reset empties the group: no members, AND all ones, OR zero, not synchronized.
module sync_group_ready_aggregator_core #(
  parameter int CLIENTS    = 16,
  parameter int EVENT_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [1:0] command, [5:2] client, [13:6] events, [21:14] yesno, [23:22] zero
  input  logic [sgra_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] group AND mask, [15:8] group OR mask, [16] event_zero_changed,
  // [17] event_zero_level, [18] group_synchronized, [23:19] member_count,
  // [25:24] status, [31:26] zero
  output logic [sgra_pkg::OUT_DATA_W-1:0] out_tdata
);
  import sgra_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  sgra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  sgra_dp #(
    .CLIENTS    (CLIENTS),
    .EVENT_BITS (EVENT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// ----- rtl/core/sgra_ctrl.sv -----
// Command sequencer for the sync group ready aggregator.
module sgra_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sgra_pkg::dp_sts_t sts,
  output sgra_pkg::dp_ctl_t ctl
);
  import sgra_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_MODIFY = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_TAIL   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    ctl          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl.apply = 1'b1;
        if (sts.skip) begin
          state_nxt = S_FIN;
        end else if (sts.is_update) begin
          state_nxt = S_MODIFY;
        end else begin
          state_nxt = S_SWEEP;
        end
      end
      S_MODIFY: begin
        ctl.upd_wr = 1'b1;
        state_nxt  = S_SWEEP;
      end
      S_SWEEP: begin
        ctl.sweep_rd = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/sgra_dp.sv -----
// Datapath: member slots, mask memory, AND/OR sweep and result register.
module sgra_dp #(
  parameter int CLIENTS    = 16,
  parameter int EVENT_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [sgra_pkg::IN_DATA_W-1:0]      in_data,
  input  sgra_pkg::dp_ctl_t                   ctl,
  output sgra_pkg::dp_sts_t                   sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sgra_pkg::OUT_DATA_W-1:0]     out_data
);
  import sgra_pkg::*;

  localparam int IDX_W = $clog2(CLIENTS);
  localparam int CNT_W = $clog2(CLIENTS + 1);
  localparam logic [EVENT_BITS-1:0] EVT_ALL = '1;

  // latched command word
  logic [CMD_W-1:0]      cmd_r;
  logic [IDX_W-1:0]      slot_r;
  logic                  slot_ok_r;
  logic [EVENT_BITS-1:0] ev_r, yn_r;

  // group state
  logic [CLIENTS-1:0]    present_r;
  logic [CNT_W-1:0]      count_r;
  logic                  sync_r;
  logic [EVENT_BITS-1:0] and_r, or_r;

  // per-command working state
  logic                  rebuilt_r;
  logic                  notify_ok_r;
  logic [STAT_W-1:0]     stat_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  acc_v_r;
  logic                  pres_pipe_r;
  logic [EVENT_BITS-1:0] and_acc_r, or_acc_r;

  // mask memory
  logic [EVENT_BITS-1:0] mask_mem [CLIENTS];
  logic [EVENT_BITS-1:0] rdata_r;
  logic [IDX_W-1:0]      raddr;
  logic                  wr_en;
  logic [EVENT_BITS-1:0] wdata;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [31:0]           client_ext;
  logic                  present_slot;
  logic [STAT_W-1:0]     stat_now;
  logic                  skip_now;
  logic [EVENT_BITS-1:0] upd_mask;
  logic [EVENT_BITS-1:0] new_and, new_or;
  logic                  changed;

  assign client_ext   = 32'(in_data[CMD_W +: CLIENT_W]);
  assign present_slot = slot_ok_r && present_r[slot_r];

  always_comb begin
    stat_now = STAT_OK;
    skip_now = 1'b0;
    case (cmd_r)
      CMD_ADD: begin
        if (!slot_ok_r) begin
          stat_now = STAT_ABSENT;
          skip_now = 1'b1;
        end else if (present_slot) begin
          stat_now = STAT_DUP;
          skip_now = 1'b1;
        end
      end
      CMD_REMOVE, CMD_UPDATE: begin
        if (!present_slot) begin
          stat_now = STAT_ABSENT;
          skip_now = 1'b1;
        end
      end
      default: begin
        skip_now = 1'b1;
      end
    endcase
  end

  assign sts.skip       = skip_now;
  assign sts.is_update  = (cmd_r == CMD_UPDATE);
  assign sts.sweep_last = (idx_r == IDX_W'(CLIENTS - 1));
  assign sts.out_free   = !out_valid_r || out_ready;

  // set where events&yesno, clear where events&~yesno
  assign upd_mask = (rdata_r & ~(ev_r & ~yn_r)) | (ev_r & yn_r);

  assign raddr = ctl.sweep_rd ? idx_r : slot_r;
  assign wr_en = ctl.upd_wr ||
                 (ctl.apply && !skip_now && (cmd_r == CMD_ADD || cmd_r == CMD_REMOVE));
  assign wdata = ctl.upd_wr ? upd_mask : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mask_mem[slot_r] <= wdata;
    end
    rdata_r <= mask_mem[raddr];
  end

  // input latch
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r     <= in_data[0 +: CMD_W];
      slot_r    <= client_ext[IDX_W-1:0];
      slot_ok_r <= (client_ext < 32'(CLIENTS));
      ev_r      <= EVENT_BITS'(in_data[CMD_W + CLIENT_W +: EV_W]);
      yn_r      <= EVENT_BITS'(in_data[CMD_W + CLIENT_W + EV_W +: EV_W]);
    end
  end

  // membership and command bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= '0;
      count_r     <= '0;
      sync_r      <= 1'b0;
      rebuilt_r   <= 1'b0;
      notify_ok_r <= 1'b0;
      stat_r      <= STAT_OK;
    end else if (ctl.apply) begin
      stat_r    <= stat_now;
      rebuilt_r <= !skip_now;
      if (!skip_now) begin
        case (cmd_r)
          CMD_ADD: begin
            present_r[slot_r] <= 1'b1;
            count_r           <= count_r + CNT_W'(1);
            notify_ok_r       <= (count_r != '0);
            if (count_r != '0) begin
              sync_r <= 1'b1;
            end
          end
          CMD_REMOVE: begin
            present_r[slot_r] <= 1'b0;
            count_r           <= count_r - CNT_W'(1);
            notify_ok_r       <= (count_r != CNT_W'(1));
          end
          default: begin
            notify_ok_r <= 1'b1;
          end
        endcase
      end
    end
  end

  // sweep over all slots, one memory read per cycle, each read accumulated in the cycle after it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_v_r <= 1'b0;
    end else begin
      acc_v_r <= ctl.sweep_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      idx_r     <= '0;
      and_acc_r <= EVT_ALL;
      or_acc_r  <= '0;
    end else begin
      if (ctl.sweep_rd) begin
        idx_r       <= idx_r + IDX_W'(1);
        pres_pipe_r <= present_r[idx_r];
      end
      if (acc_v_r && pres_pipe_r) begin
        and_acc_r <= and_acc_r & rdata_r;
        or_acc_r  <= or_acc_r | rdata_r;
      end
    end
  end

  assign new_and = rebuilt_r ? and_acc_r : and_r;
  assign new_or  = rebuilt_r ? or_acc_r : or_r;
  assign changed = rebuilt_r && (new_and[0] ^ and_r[0]) && notify_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      and_r <= EVT_ALL;
      or_r  <= '0;
    end else if (ctl.finish) begin
      and_r <= new_and;
      or_r  <= new_or;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_data_r <= {6'b0,
                     stat_r,
                     CNT_O_W'(32'(count_r)),
                     sync_r,
                     new_and[0],
                     changed,
                     EV_W'(new_or),
                     EV_W'(new_and)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- verif/sync_group_ready_aggregator_core_tb.sv -----
// Self-checking testbench for the sync group ready aggregator core.
module sync_group_ready_aggregator_core_tb;
  import sgra_pkg::*;

  localparam int CLIENTS = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // packed in the order of the input word, lowest field last
  typedef struct packed {
    logic [EV_W-1:0]     yesno;
    logic [EV_W-1:0]     events;
    logic [CLIENT_W-1:0] slot;
    logic [CMD_W-1:0]    op;
  } group_cmd_t;

  // packed in the order of the result word, lowest field last
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [CNT_O_W-1:0] members;
    logic               synced;
    logic               zero_level;
    logic               zero_changed;
    logic [EV_W-1:0]    or_mask;
    logic [EV_W-1:0]    and_mask;
  } group_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  group_cmd_t    pending_cmds[$];
  group_report_t reports_due[$];
  group_cmd_t    cmd_on_bus;
  int            cmds_taken = 0;
  int            mismatches = 0;
  logic          hold_out = 1'b0;
  logic          steady;

  // group state as the block should hold it
  logic [EV_W-1:0] slot_mask[CLIENTS];
  logic            slot_present[CLIENTS];
  logic [EV_W-1:0] grp_and = '1;
  logic [EV_W-1:0] grp_or = '0;
  logic            grp_synced = 1'b0;

  sync_group_ready_aggregator_core #(
    .CLIENTS   (CLIENTS),
    .EVENT_BITS(EV_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no idling on either side over this stretch of words
  assign steady = (cmds_taken >= 100) && (cmds_taken < 200);

  function automatic int member_total();
    int n;
    n = 0;
    for (int i = 0; i < CLIENTS; i++) n += slot_present[i] ? 1 : 0;
    return n;
  endfunction

  // applies one command to the group state, returns the result word it causes
  function automatic group_report_t aggregate_command(group_cmd_t c);
    group_report_t   r;
    logic [EV_W-1:0] old_and;
    logic            rebuilt;
    logic            hit;
    int              notify;
    old_and = grp_and;
    rebuilt = 1'b0;
    notify = 0;
    hit = slot_present[c.slot];
    r = '0;
    r.status = STAT_OK;
    case (c.op)
      CMD_ADD: begin
        if (hit) begin
          r.status = STAT_DUP;
        end else begin
          notify = member_total();  // only members present before the add
          if (notify > 0) grp_synced = 1'b1;
          slot_mask[c.slot] = '0;
          slot_present[c.slot] = 1'b1;
          rebuilt = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!hit) begin
          r.status = STAT_ABSENT;
        end else begin
          slot_present[c.slot] = 1'b0;
          slot_mask[c.slot] = '0;
          rebuilt = 1'b1;
        end
      end
      CMD_UPDATE: begin
        if (!hit) begin
          r.status = STAT_ABSENT;
        end else begin
          slot_mask[c.slot] = (slot_mask[c.slot] & ~(c.events & ~c.yesno)) |
                              (c.events & c.yesno);
          rebuilt = 1'b1;
        end
      end
      default: ;
    endcase
    if (rebuilt) begin
      grp_and = '1;
      grp_or = '0;
      for (int i = 0; i < CLIENTS; i++) begin
        if (slot_present[i]) begin
          grp_and &= slot_mask[i];
          grp_or |= slot_mask[i];
        end
      end
      if (c.op != CMD_ADD) notify = member_total();
    end
    r.and_mask = grp_and;
    r.or_mask = grp_or;
    r.zero_changed = rebuilt && (old_and[0] != grp_and[0]) && (notify > 0);
    r.zero_level = grp_and[0];
    r.synced = grp_synced;
    r.members = CNT_O_W'(member_total());
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic queue_cmd(logic [CMD_W-1:0] op, int slot, int ev, int yn);
    group_cmd_t c;
    c.op = op;
    c.slot = CLIENT_W'(slot);
    c.events = EV_W'(ev);
    c.yesno = EV_W'(yn);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        reports_due.insert(reports_due.size(), aggregate_command(cmd_on_bus));
        cmds_taken <= cmds_taken + 1;
      end
      if (in_tvalid && !in_tready) begin
        // word still offered, hold it
      end else if (pending_cmds.size() > 0 && (steady || $urandom_range(0, 99) >= 22)) begin
        cmd_on_bus = pending_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {2'b00, cmd_on_bus};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    group_report_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[25:0];
        if (reports_due.size() == 0) begin
          report_mismatch("result word with nothing outstanding", out_tdata, 0);
        end else begin
          want = reports_due.pop_front();
          if (out_tdata[31:26] != '0)
            report_mismatch("pad bits", out_tdata[31:26], 0);
          if (got.and_mask != want.and_mask)
            report_mismatch("group and mask", got.and_mask, want.and_mask);
          if (got.or_mask != want.or_mask)
            report_mismatch("group or mask", got.or_mask, want.or_mask);
          if (got.zero_changed != want.zero_changed)
            report_mismatch("event_zero_changed", got.zero_changed, want.zero_changed);
          if (got.zero_level != want.zero_level)
            report_mismatch("event_zero_level", got.zero_level, want.zero_level);
          if (got.synced != want.synced)
            report_mismatch("group_synchronized", got.synced, want.synced);
          if (got.members != want.members)
            report_mismatch("member_count", got.members, want.members);
          if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
        end
      end
      out_tready <= !hold_out && (steady || $urandom_range(0, 99) >= 22);
    end
  end

  // long receiver stall so the block backs up into its input
  initial begin
    while (cmds_taken < 300) @(posedge clk);
    hold_out <= 1'b1;
    repeat (300) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [CLIENTS-1:0] occupied;
    logic               filling;
    logic [CMD_W-1:0]   kind;
    int                 pick, slot, ev, yn, n;
    for (int i = 0; i < CLIENTS; i++) begin
      slot_mask[i] = '0;
      slot_present[i] = 1'b0;
    end

    // directed part
    queue_cmd(CMD_UNUSED, 0, 8'h00, 8'h00);    // unused command on empty group
    queue_cmd(CMD_UPDATE, 0, 8'hff, 8'hff);    // update of absent member
    queue_cmd(CMD_REMOVE, 15, 8'h00, 8'h00);   // remove of absent member
    queue_cmd(CMD_ADD, 0, 8'h00, 8'h00);       // first member, not synced
    queue_cmd(CMD_ADD, 0, 8'hff, 8'hff);       // duplicate add
    queue_cmd(CMD_UPDATE, 0, 8'hff, 8'hff);    // bit 0 rises
    queue_cmd(CMD_UPDATE, 0, 8'h01, 8'h00);    // bit 0 falls
    queue_cmd(CMD_UPDATE, 0, 8'h00, 8'hff);    // empty event mask, no change
    queue_cmd(CMD_ADD, 15, 8'h00, 8'h00);      // second member syncs the group
    queue_cmd(CMD_UPDATE, 15, 8'hff, 8'hff);
    queue_cmd(CMD_UPDATE, 0, 8'hff, 8'hff);    // all ones across the group
    queue_cmd(CMD_UPDATE, 0, 8'haa, 8'h55);    // clear half
    queue_cmd(CMD_UPDATE, 15, 8'h55, 8'haa);
    queue_cmd(CMD_UNUSED, 15, 8'hff, 8'hff);   // unused command, all bits high
    queue_cmd(CMD_REMOVE, 15, 8'h00, 8'h00);
    queue_cmd(CMD_REMOVE, 0, 8'h00, 8'h00);    // group empty, nobody to notify
    queue_cmd(CMD_ADD, 7, 8'h00, 8'h00);
    queue_cmd(CMD_REMOVE, 7, 8'hff, 8'hff);
    queue_cmd(CMD_ADD, 1, 8'h00, 8'h00);
    queue_cmd(CMD_ADD, 2, 8'h00, 8'h00);
    queue_cmd(CMD_UPDATE, 1, 8'hff, 8'hff);
    queue_cmd(CMD_REMOVE, 2, 8'h00, 8'h00);    // remove lifts bit 0, one left
    queue_cmd(CMD_ADD, 2, 8'h00, 8'h00);       // add drops bit 0
    queue_cmd(CMD_REMOVE, 1, 8'h00, 8'h00);
    queue_cmd(CMD_REMOVE, 2, 8'h00, 8'h00);

    // random part: mostly legal commands that fill and drain the group
    occupied = '0;
    filling = 1'b1;
    for (int i = 0; i < 450; i++) begin
      pick = $urandom_range(0, 99);
      ev = $urandom_range(0, 255);
      yn = $urandom_range(0, 255);
      if (pick < 20) begin
        kind = CMD_W'($urandom_range(0, 3));
        slot = $urandom_range(0, CLIENTS - 1);
      end else begin
        pick = $urandom_range(0, 99);
        if (filling) kind = (pick < 50) ? CMD_ADD : (pick < 85) ? CMD_UPDATE : CMD_REMOVE;
        else kind = (pick < 15) ? CMD_ADD : (pick < 50) ? CMD_UPDATE : CMD_REMOVE;
        if (kind == CMD_ADD && &occupied) kind = CMD_UPDATE;
        if (kind != CMD_ADD && occupied == '0) kind = CMD_ADD;
        do slot = $urandom_range(0, CLIENTS - 1);
        while (occupied[slot] != (kind != CMD_ADD));
        if (kind == CMD_UPDATE) begin
          pick = $urandom_range(0, 2);
          if (pick == 0) begin
            ev = 8'hff;
            yn = 8'hff;
          end else if (pick == 1) begin
            ev = ev | 8'h01;
          end
        end
      end
      queue_cmd(kind, slot, ev, yn);
      if (kind == CMD_ADD) occupied[slot] = 1'b1;
      if (kind == CMD_REMOVE) occupied[slot] = 1'b0;
      n = $countones(occupied);
      if (n == CLIENTS) filling = 1'b0;
      if (n == 0) filling = 1'b1;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_tvalid || reports_due.size() != 0)
      @(posedge clk);
    repeat (CLIENTS + 8) @(posedge clk);
    if (mismatches == 0 && reports_due.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
